// ===== rtl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Holds the sequencer state type and the fixed field widths.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = 33;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_SW,
    S_NEXT,
    S_DONE,
    S_OUT
  } rmth_state_t;

endpackage

// ===== rtl/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 514
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over a max-heap and a min-heap
// Each word inserts one sample (dropped if the store is full) and returns twice the median,
// the count and the dropped flag.
// Operation: after a sample is accepted, S_DECIDE picks the heap that grows, S_UP and
// S_UP_CMP sift the new value up, and when the sample crosses the other heap's top, S_DN to
// S_DN_SW sift the sample down from that heap's root; S_DONE registers the result and S_OUT
// holds it until taken. A full store skips the sifts. in_stall is high outside S_IDLE, so no
// new sample is taken before the previous word has been accepted on the output.
// Reset: rst clears the counts and the sequencer; heap memories are not cleared.
module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MEDIAN_W-1:0] median_doubled,
  output logic [COUNT_W-1:0]         sample_count,
  output logic                       dropped
);

  // Each heap holds at most half of the store plus a small margin.
  localparam int unsigned HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned TW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;

  rmth_state_t state, state_next;

  // Working registers of the shared sift unit. sel high means the lower
  // (max) heap is being worked on, low means the upper (min) heap.
  logic                sel, sel_next;
  logic [SAMPLE_W-1:0] vreg, vreg_next;
  logic [SAMPLE_W-1:0] lval, lval_next;
  logic [SAMPLE_W-1:0] smp, smp_next;
  logic [AW-1:0]       idx, idx_next;
  logic [AW-1:0]       bidx, bidx_next;
  logic [CW-1:0]       ncnt, ncnt_next;
  logic                pend_b, pend_b_next;
  logic                drop, drop_next;

  logic [CW-1:0]       lower_count, lower_count_next;
  logic [CW-1:0]       upper_count, upper_count_next;
  logic [SAMPLE_W-1:0] lower_top, upper_top;

  // Memory ports, shared address for both heaps.
  logic                we_lo, we_up;
  logic [AW-1:0]       raddr;
  logic [SAMPLE_W-1:0] wdata;
  logic [SAMPLE_W-1:0] rd_lo, rd_up, rd;

  // Shared compare unit.
  logic [SAMPLE_W-1:0] cmp_a, cmp_b;
  logic                cmp_max, above;

  logic [TW-1:0]       total;
  logic                full, balanced;
  logic [XW-1:0]       left, right;
  logic                left_ok, right_ok;
  logic [AW-1:0]       parent;

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_lower_ram (
    .clk(clk), .we(we_lo), .waddr(idx), .wdata(wdata), .raddr(raddr), .rdata(rd_lo)
  );

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(HEAP_DEPTH)) u_upper_ram (
    .clk(clk), .we(we_up), .waddr(idx), .wdata(wdata), .raddr(raddr), .rdata(rd_up)
  );

  assign rd       = sel ? rd_lo : rd_up;
  assign total    = TW'(lower_count) + TW'(upper_count);
  assign full     = (32'(total) >= CAPACITY);
  assign balanced = (lower_count == upper_count);
  assign left     = {1'b0, idx, 1'b1};
  assign right    = left + XW'(1);
  assign left_ok  = (left < XW'(ncnt));
  assign right_ok = (right < XW'(ncnt));
  assign parent   = AW'((idx - AW'(1)) >> 1);

  // One signed compare, ordered for a max-heap or a min-heap.
  always_comb begin
    cmp_a   = vreg;
    cmp_b   = rd;
    cmp_max = sel;
    unique case (state)
      S_DECIDE: begin
        // Balanced: does the sample belong above the upper top?
        // Unbalanced: does it belong below the lower top?
        cmp_a   = smp;
        cmp_b   = balanced ? upper_top : lower_top;
        cmp_max = balanced;
      end
      S_DN_CMP: begin
        cmp_a = rd;
        cmp_b = lval;
      end
      S_DN_SW: begin
        cmp_a = lval;
        cmp_b = vreg;
      end
      default: begin
        cmp_a = vreg;
        cmp_b = rd;
      end
    endcase
    above = cmp_max ? ($signed(cmp_a) > $signed(cmp_b))
                    : ($signed(cmp_a) < $signed(cmp_b));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECIDE;
      S_DECIDE: state_next = full ? S_DONE : S_UP;
      S_UP:     state_next = (idx == '0) ? S_NEXT : S_UP_CMP;
      S_UP_CMP: state_next = above ? S_UP : S_NEXT;
      S_DN:     state_next = left_ok ? S_DN_RDR : S_NEXT;
      S_DN_RDR: state_next = S_DN_CMP;
      S_DN_CMP: state_next = S_DN_SW;
      S_DN_SW:  state_next = above ? S_DN : S_NEXT;
      S_NEXT:   state_next = pend_b ? S_DN : S_DONE;
      S_DONE:   state_next = S_OUT;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    sel_next         = sel;
    vreg_next        = vreg;
    lval_next        = lval;
    smp_next         = smp;
    idx_next         = idx;
    bidx_next        = bidx;
    ncnt_next        = ncnt;
    pend_b_next      = pend_b;
    drop_next        = drop;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    we_lo            = 1'b0;
    we_up            = 1'b0;
    wdata            = vreg;
    raddr            = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          smp_next = sample;
        end
      end
      S_DECIDE: begin
        drop_next   = full;
        pend_b_next = 1'b0;
        if (balanced) begin
          // Lower heap grows. A sample above the upper top swaps with it.
          sel_next         = 1'b1;
          idx_next         = AW'(lower_count);
          lower_count_next = full ? lower_count : lower_count + CW'(1);
          if ((upper_count != '0) && above && !full) begin
            vreg_next   = upper_top;
            pend_b_next = 1'b1;
          end else begin
            vreg_next = smp;
          end
        end else begin
          // Upper heap grows. A sample below the lower top swaps with it.
          sel_next         = 1'b0;
          idx_next         = AW'(upper_count);
          upper_count_next = full ? upper_count : upper_count + CW'(1);
          if (above && !full) begin
            vreg_next   = lower_top;
            pend_b_next = 1'b1;
          end else begin
            vreg_next = smp;
          end
        end
      end
      S_UP: begin
        raddr = parent;
        if (idx == '0) begin
          we_lo = sel;
          we_up = !sel;
        end
      end
      S_UP_CMP: begin
        we_lo = sel;
        we_up = !sel;
        if (above) begin
          wdata    = rd;
          idx_next = parent;
        end
      end
      S_DN: begin
        raddr = AW'(left);
        if (!left_ok) begin
          we_lo = sel;
          we_up = !sel;
        end
      end
      S_DN_RDR: begin
        raddr     = AW'(right);
        lval_next = rd;
      end
      S_DN_CMP: begin
        if (right_ok && above) begin
          lval_next = rd;
          bidx_next = AW'(right);
        end else begin
          bidx_next = AW'(left);
        end
      end
      S_DN_SW: begin
        we_lo = sel;
        we_up = !sel;
        if (above) begin
          wdata    = lval;
          idx_next = bidx;
        end
      end
      S_NEXT: begin
        if (pend_b) begin
          // Replace the other heap's top with the sample and sift it down.
          sel_next    = !sel;
          vreg_next   = smp;
          idx_next    = '0;
          ncnt_next   = sel ? upper_count : lower_count;
          pend_b_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lower_count <= '0;
      upper_count <= '0;
      pend_b      <= 1'b0;
    end else begin
      state       <= state_next;
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      pend_b      <= pend_b_next;
    end
  end

  always_ff @(posedge clk) begin
    sel  <= sel_next;
    vreg <= vreg_next;
    lval <= lval_next;
    smp  <= smp_next;
    idx  <= idx_next;
    bidx <= bidx_next;
    ncnt <= ncnt_next;
    drop <= drop_next;
    // Mirror the root of each heap so the median needs no memory read.
    if (we_lo && (idx == '0)) lower_top <= wdata;
    if (we_up && (idx == '0)) upper_top <= wdata;
    if (state == S_DONE) begin
      if (lower_count > upper_count) begin
        median_doubled <= {lower_top, 1'b0};
      end else begin
        median_doubled <= {lower_top[SAMPLE_W-1], lower_top}
                        + {upper_top[SAMPLE_W-1], upper_top};
      end
      sample_count <= COUNT_W'(total);
      dropped      <= drop;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // The heaps stay balanced, the lower one never short.
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (lower_count == upper_count) || (lower_count == upper_count + CW'(1)))
    else $error("heap counts out of balance");

  // The store never holds more than its capacity.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= CAPACITY)
    else $error("store over capacity");

  // A dropped word is only reported when the store is full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> full)
    else $error("drop reported while store not full");

  // A pending swap only exists while a heap operation is in flight.
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_b)
    else $error("pending sift-down left over in idle");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the running median block
// Feeds signed samples through the valid/stall handshake, keeps its own
// two-heap model of the running set, and compares every returned word.
// ----------------------------------------------------------------------------

// Keeps the expected results and a two-heap model of the samples held.
class median_tracker;
  localparam int unsigned CAP = 1024;
  localparam int unsigned DEPTH = CAP / 2 + 2;

  longint lo_heap[DEPTH];
  longint hi_heap[DEPTH];
  int unsigned lo_n;
  int unsigned hi_n;
  logic [32:0] want_median[$];
  logic [10:0] want_count[$];
  logic        want_drop[$];
  int unsigned errors;

  function void clear();
    lo_n = 0;
    hi_n = 0;
    errors = 0;
  endfunction

  function bit ranks_higher(longint a, longint b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function void heap_add(bit is_max, longint v);
    int unsigned i;
    int unsigned p;
    longint t;
    if (is_max) begin
      i = lo_n;
      lo_heap[i] = v;
      lo_n++;
    end else begin
      i = hi_n;
      hi_heap[i] = v;
      hi_n++;
    end
    while (i > 0) begin
      p = (i - 1) / 2;
      if (is_max) begin
        if (!ranks_higher(lo_heap[i], lo_heap[p], 1)) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
      end else begin
        if (!ranks_higher(hi_heap[i], hi_heap[p], 0)) break;
        t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
      end
      i = p;
    end
  endfunction

  function longint heap_take(bit is_max);
    longint h[DEPTH];
    int unsigned n;
    int unsigned i;
    int unsigned l;
    int unsigned best;
    longint top;
    longint t;
    if (is_max) begin
      h = lo_heap;
      n = lo_n;
    end else begin
      h = hi_heap;
      n = hi_n;
    end
    top = h[0];
    n--;
    h[0] = h[n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && ranks_higher(h[l], h[best], is_max)) best = l;
      if (l + 1 < n && ranks_higher(h[l+1], h[best], is_max)) best = l + 1;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
    if (is_max) begin
      lo_heap = h; lo_n = n;
    end else begin
      hi_heap = h; hi_n = n;
    end
    return top;
  endfunction

  // Notes one accepted sample and queues the word it must produce.
  function void note_sample(logic signed [31:0] s);
    longint med;
    bit full;
    full = (lo_n + hi_n >= CAP);
    if (!full) begin
      heap_add(1, longint'(s));
      heap_add(0, heap_take(1));
      if (hi_n > lo_n) heap_add(1, heap_take(0));
    end
    if (lo_n > hi_n) med = 2 * lo_heap[0];
    else med = lo_heap[0] + hi_heap[0];
    want_median.push_back(med[32:0]);
    want_count.push_back(11'(lo_n + hi_n));
    want_drop.push_back(full);
  endfunction

  function void check_word(logic [32:0] med, logic [10:0] cnt, logic drop);
    logic [32:0] em;
    logic [10:0] ec;
    logic        ed;
    if (want_median.size() == 0) begin
      $error("unexpected word: median_doubled %0d", $signed(med));
      errors++;
      return;
    end
    em = want_median.pop_front();
    ec = want_count.pop_front();
    ed = want_drop.pop_front();
    if (med !== em) begin
      $error("median_doubled expected %0d actual %0d", $signed(em), $signed(med));
      errors++;
    end
    if (cnt !== ec) begin
      $error("sample_count expected %0d actual %0d", ec, cnt);
      errors++;
    end
    if (drop !== ed) begin
      $error("dropped expected %0d actual %0d", ed, drop);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return want_median.size();
  endfunction
endclass

module tb_top;
  import rmth_pkg::*;

  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned HOLD_LEN = 300;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b1;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic [COUNT_W-1:0]         sample_count;
  logic                       dropped;

  // Idle odds in percent for each side; the stimulus moves them by phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // The stimulus bumps hold_req to ask for one long hold-off; the receiver
  // notes it in hold_ack and counts the stretch down in recv_hold.
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned recv_hold = 0;
  int unsigned quiet_cycles = 0;
  bit          in_reset_done = 0;

  median_tracker tracker;

  running_median_two_heaps dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .median_doubled(median_doubled), .sample_count(sample_count),
    .dropped(dropped)
  );

  always #6 clk = ~clk;

  // The receiver checks each accepted word and draws its next stall. A long
  // hold-off is counted here so that the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        tracker.check_word(median_doubled, sample_count, dropped);
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        recv_hold <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (recv_hold > 0) begin
        out_stall <= 1'b1;
        recv_hold <= recv_hold - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (in_reset_done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one sample, idling first at random, and holds it until accepted.
  // Valid stays up after acceptance; the next call or wait_drained drops it.
  task automatic send_word(logic signed [31:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // Mostly small values so that equal samples and ties show up, with the
  // occasional full-range value and extreme.
  function automatic logic signed [31:0] pick_sample();
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed(32'($urandom_range(40))) - 20;
    endcase
  endfunction

  initial begin
    tracker = new();
    tracker.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    in_reset_done <= 1'b1;
    recv_idle_pct = 0;

    // Directed: extremes, ties, negatives and sums that need the 33rd bit.
    send_word(32'sh7fffffff);
    send_word(32'sh7fffffff);
    send_word(32'sh80000000);
    send_word(32'sh80000000);
    send_word(32'sh80000000);
    send_word(0);
    send_word(-1);
    send_word(1);
    send_word(32'sh55555555);
    send_word(32'shaaaaaaaa);
    send_word(5);
    send_word(5);
    send_word(5);
    send_word(-7);
    send_word(100);
    send_word(32'sh7ffffffe);

    // Long receiver hold-off while the sender keeps offering samples: the block stalls its input.
    hold_req = hold_req + 1;
    repeat (6) send_word(pick_sample());
    wait_drained();

    // The random part fills the store to capacity, so the store-full case
    // follows with the dropped flag and an unchanged median.
    send_idle_pct = 28;
    recv_idle_pct = 79;
    repeat (430) send_word(pick_sample());
    send_idle_pct = 79;
    recv_idle_pct = 28;
    repeat (430) send_word(pick_sample());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (130) send_word(pick_sample());
    // Sender pauses until every expected word is back.
    wait_drained();
    repeat (290) send_word(pick_sample());
    send_word(32'sh7fffffff);
    send_word(32'sh80000000);

    wait_drained();
    repeat (80) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rmth_pkg.sv
rtl/rmth_ram.sv
rtl/running_median_two_heaps.sv
test/tb_top.sv
